// File: hdl/leg_pkg.sv
package leg_pkg;

   // default line capacity in characters
   localparam int LINE_CAPACITY_DEFAULT = 64;

   // editing keys
   localparam logic [7:0] KEY_LEFT  = 8'h3C;   // '<'
   localparam logic [7:0] KEY_RIGHT = 8'h3E;   // '>'
   localparam logic [7:0] KEY_DEL   = 8'h2D;   // '-'

   // rsp_tuser bit positions
   localparam int USER_CHAR_VALID = 0;
   localparam int USER_DROPPED    = 1;
   localparam int USER_WIDTH      = 2;

endpackage

// File: hdl/leg_stack_ram.sv
// one stack of the gap buffer: one write port, one registered read port
module leg_stack_ram #(
   parameter int DEPTH = leg_pkg::LINE_CAPACITY_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);

   logic [7:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/line_editor_gap_buffer.sv
// Keystroke line editor on a gap buffer held in two stack memories. Each req item is a key
// byte (tdata) or, with tlast high, an end of line. Insert, delete and cursor moves at an
// edge finish in the cycle they are accepted; a cursor move that shifts a character reads
// one stack, then writes the other, through the registered read port of the stack memories.
// An end of line streams the text out one character per rsp item, left stack bottom to top
// and then right stack top to bottom, at one character per cycle when rsp_tready stays
// high; an empty line gives one item with char_valid low. The block accepts no req item
// while a line is being read out. Inserts into a full line are dropped and flagged on every
// item of that line. No clearing pass after reset.
module line_editor_gap_buffer #(
   parameter int LINE_CAPACITY = leg_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // req channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // key
   input  logic       req_tlast,    // command (end of line)
   // rsp channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // text_char
   output logic       rsp_tlast,    // last
   output logic [leg_pkg::USER_WIDTH-1:0] rsp_tuser  // char_valid, dropped_input
);

   localparam int CW = $clog2(LINE_CAPACITY + 1);
   localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MOVE_L = 4'b0010,   // write right stack with char read from left
      ST_MOVE_R = 4'b0100,   // write left stack with char read from right
      ST_DRAIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] lc_ff, lc_in, rc_ff, rc_in;
   logic [CW-1:0] dl_ff, dl_in, dr_ff, dr_in;
   logic          ovf_ff, ovf_in;
   logic          empty_ff, empty_in;
   // pending read stage
   logic p_vld_ff, p_vld_in, p_right_ff, p_right_in;
   logic p_cv_ff, p_cv_in, p_last_ff, p_last_in, p_drop_ff, p_drop_in;
   // output register
   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_cv_ff, out_cv_in, out_last_ff, out_last_in, out_drop_ff, out_drop_in;

   // memory ports
   logic          l_re, l_we, r_re, r_we;
   logic [AW-1:0] l_raddr, l_waddr, r_raddr, r_waddr;
   logic [7:0]    l_wdata, r_wdata, l_rdata, r_rdata;

   logic          accept, adv, issue, more, left_phase, right_phase, room;
   logic          is_left, is_right, is_del;
   logic [CW-1:0] lc_dec, rc_dec, dr_dec, dl_inc, used;

   leg_stack_ram #(.DEPTH(LINE_CAPACITY), .AW(AW)) u_left (
      .clock   (clock),
      .rd_en   (l_re),
      .rd_addr (l_raddr),
      .rd_data (l_rdata),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata)
   );

   leg_stack_ram #(.DEPTH(LINE_CAPACITY), .AW(AW)) u_right (
      .clock   (clock),
      .rd_en   (r_re),
      .rd_addr (r_raddr),
      .rd_data (r_rdata),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata)
   );

   // decode and counters
   assign accept   = req_tvalid & req_tready;
   assign is_left  = (req_tdata == leg_pkg::KEY_LEFT);
   assign is_right = (req_tdata == leg_pkg::KEY_RIGHT);
   assign is_del   = (req_tdata == leg_pkg::KEY_DEL);
   assign lc_dec   = lc_ff - 1'b1;
   assign rc_dec   = rc_ff - 1'b1;
   assign dr_dec   = dr_ff - 1'b1;
   assign dl_inc   = dl_ff + 1'b1;
   assign used     = lc_ff + rc_ff;
   assign room     = (used < CAP);

   // readout sequencing
   assign left_phase  = (dl_ff < lc_ff);
   assign right_phase = !left_phase && (dr_ff != '0);
   assign more        = empty_ff | left_phase | right_phase;
   assign adv         = !out_vld_ff || rsp_tready;
   assign issue       = (state_ff == ST_DRAIN) && adv && more;

   // next state
   always_comb begin
      state_in   = state_ff;
      lc_in      = lc_ff;
      rc_in      = rc_ff;
      dl_in      = dl_ff;
      dr_in      = dr_ff;
      ovf_in     = ovf_ff;
      empty_in   = empty_ff;
      p_vld_in   = p_vld_ff;
      p_right_in = p_right_ff;
      p_cv_in    = p_cv_ff;
      p_last_in  = p_last_ff;
      p_drop_in  = p_drop_ff;
      l_re    = 1'b0;
      l_raddr = dl_ff[AW-1:0];
      l_we    = 1'b0;
      l_waddr = lc_ff[AW-1:0];
      l_wdata = req_tdata;
      r_re    = 1'b0;
      r_raddr = dr_dec[AW-1:0];
      r_we    = 1'b0;
      r_waddr = rc_ff[AW-1:0];
      r_wdata = l_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tlast) begin
                  state_in = ST_DRAIN;
                  dl_in    = '0;
                  dr_in    = rc_ff;
                  empty_in = (used == '0);
               end else if (is_left) begin
                  if (lc_ff != '0 && rc_ff < CAP) begin
                     l_re     = 1'b1;
                     l_raddr  = lc_dec[AW-1:0];
                     lc_in    = lc_dec;
                     state_in = ST_MOVE_L;
                  end
               end else if (is_right) begin
                  if (rc_ff != '0 && lc_ff < CAP) begin
                     r_re     = 1'b1;
                     r_raddr  = rc_dec[AW-1:0];
                     rc_in    = rc_dec;
                     state_in = ST_MOVE_R;
                  end
               end else if (is_del) begin
                  if (lc_ff != '0) begin
                     lc_in = lc_dec;
                  end
               end else if (room) begin
                  l_we  = 1'b1;
                  lc_in = lc_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_MOVE_L: begin
            r_we     = 1'b1;
            rc_in    = rc_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_MOVE_R: begin
            l_we     = 1'b1;
            l_wdata  = r_rdata;
            lc_in    = lc_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (issue) begin
               p_drop_in = ovf_ff;
               if (empty_ff) begin
                  empty_in   = 1'b0;
                  p_cv_in    = 1'b0;
                  p_right_in = 1'b0;
                  p_last_in  = 1'b1;
               end else if (left_phase) begin
                  l_re       = 1'b1;
                  dl_in      = dl_inc;
                  p_cv_in    = 1'b1;
                  p_right_in = 1'b0;
                  p_last_in  = (dl_inc == lc_ff) && (dr_ff == '0);
               end else begin
                  r_re       = 1'b1;
                  dr_in      = dr_dec;
                  p_cv_in    = 1'b1;
                  p_right_in = 1'b1;
                  p_last_in  = (dr_ff == CW'(1));
               end
            end
            // line fully handed to the output register
            if (!more && !p_vld_ff) begin
               state_in = ST_IDLE;
               lc_in    = '0;
               rc_in    = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         p_vld_in = issue;
      end
   end

   // output register load
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_char_in = out_char_ff;
      out_cv_in   = out_cv_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;
      if (adv) begin
         out_vld_in  = p_vld_ff;
         out_char_in = !p_cv_ff ? 8'h00 : (p_right_ff ? r_rdata : l_rdata);
         out_cv_in   = p_cv_ff;
         out_last_in = p_last_ff;
         out_drop_in = p_drop_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         lc_ff      <= '0;
         rc_ff      <= '0;
         dl_ff      <= '0;
         dr_ff      <= '0;
         ovf_ff     <= 1'b0;
         empty_ff   <= 1'b0;
         p_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         lc_ff      <= lc_in;
         rc_ff      <= rc_in;
         dl_ff      <= dl_in;
         dr_ff      <= dr_in;
         ovf_ff     <= ovf_in;
         empty_ff   <= empty_in;
         p_vld_ff   <= p_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_right_ff  <= p_right_in;
      p_cv_ff     <= p_cv_in;
      p_last_ff   <= p_last_in;
      p_drop_ff   <= p_drop_in;
      out_char_ff <= out_char_in;
      out_cv_ff   <= out_cv_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser[leg_pkg::USER_CHAR_VALID] = out_cv_ff;
   assign rsp_tuser[leg_pkg::USER_DROPPED]    = out_drop_ff;

endmodule

// File: hdl/leg_checker.sv
// port-level checks for the line editor
module leg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [leg_pkg::USER_WIDTH-1:0] rsp_tuser
);

   // a stalled rsp item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
   else $error("rsp item changed while stalled");

   // an empty-line item is the only item of its line and carries no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[leg_pkg::USER_CHAR_VALID] |->
         rsp_tlast && (rsp_tdata == 8'h00))
   else $error("empty-line item malformed");

   // an end of line blocks further req items while the line is read out
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
   else $error("req accepted right after end of line");

   // an insert or delete leaves req ready in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && (req_tdata != leg_pkg::KEY_LEFT) &&
      (req_tdata != leg_pkg::KEY_RIGHT) |=> req_tready)
   else $error("req not ready after insert or delete");

endmodule

bind line_editor_gap_buffer leg_checker u_leg_checker (.*);
